/* src/gle_pkg.sv */
// ----------------------------------------------------------------------------
// gle_pkg
// Shared constants, command/status structs and controller states for the
// GIF-style LZW pixel encoder.
// ----------------------------------------------------------------------------
package gle_pkg;

	localparam int MAX_CODES       = 4096;
	localparam int SUB_BLOCK_BYTES = 255;
	localparam int TABLE_SLOTS     = 8192;
	localparam int SLOT_W          = $clog2(TABLE_SLOTS);
	localparam int CODE_W          = 12;
	localparam int NEXT_W          = 13;
	localparam int PIX_W           = 8;
	localparam int DEPTH_W         = 4;
	localparam int EPOCH_W         = 4;
	localparam int ENTRY_W         = EPOCH_W + CODE_W + PIX_W + CODE_W;
	localparam int ACC_W           = 20;
	localparam int PEND_W          = 5;
	localparam int SBC_W           = 8;

	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
	localparam logic [DEPTH_W-1:0] DEPTH_MIN   = DEPTH_W'(2);
	localparam logic [DEPTH_W-1:0] DEPTH_MAX   = DEPTH_W'(8);

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_SWEEP,
		S_FIRST,
		S_FIRST_PUT,
		S_READ,
		S_CMP,
		S_MISS_PUT,
		S_ADD,
		S_FULL_PUT,
		S_RESTART,
		S_CHECK,
		S_FIN_PREFIX,
		S_FIN_STOP,
		S_FLUSH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic sweep_step;
		logic restart;
		logic rd_en;
		logic probe_next;
		logic take_hit;
		logic take_pixel;
		logic put_prefix;
		logic put_clear;
		logic put_stop;
		logic add_entry;
		logic start_fin;
		logic end_image;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_pending;
		logic sweep_last;
		logic started;
		logic last_pix;
		logic hit;
		logic slot_empty;
		logic dict_full;
		logic pk_ready;
		logic fin_busy;
	} sts_t;

endpackage

/* src/gle_ram.sv */
// ----------------------------------------------------------------------------
// gle_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/gle_ctrl.sv */
// ----------------------------------------------------------------------------
// gle_ctrl
// Per-pixel sequencer: lookup probing, miss handling, image start and finish.
// ----------------------------------------------------------------------------
module gle_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  gle_pkg::sts_t sts,
	output gle_pkg::cmd_t cmd
);
	import gle_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (sts.sweep_pending) begin
					state_d = S_SWEEP;
				end else if (s_tvalid) begin
					state_d = sts.started ? S_READ : S_FIRST;
				end
			end
			S_SWEEP:      if (sts.sweep_last) state_d = S_IDLE;
			S_FIRST:      state_d = S_FIRST_PUT;
			S_FIRST_PUT:  if (sts.pk_ready) state_d = S_CHECK;
			S_READ:       state_d = S_CMP;
			S_CMP: begin
				if (sts.hit) begin
					state_d = S_CHECK;
				end else if (sts.slot_empty) begin
					state_d = S_MISS_PUT;
				end else begin
					state_d = S_READ;
				end
			end
			S_MISS_PUT: begin
				if (sts.pk_ready) begin
					state_d = sts.dict_full ? S_FULL_PUT : S_ADD;
				end
			end
			S_ADD:        state_d = S_CHECK;
			S_FULL_PUT:   if (sts.pk_ready) state_d = S_RESTART;
			S_RESTART:    state_d = S_CHECK;
			S_CHECK:      state_d = sts.last_pix ? S_FIN_PREFIX : S_IDLE;
			S_FIN_PREFIX: if (sts.pk_ready) state_d = S_FIN_STOP;
			S_FIN_STOP:   if (sts.pk_ready) state_d = S_FLUSH;
			S_FLUSH:      if (!sts.fin_busy) state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready   = !sts.sweep_pending;
				cmd.accept = s_tvalid && !sts.sweep_pending;
			end
			S_SWEEP:     cmd.sweep_step = 1'b1;
			S_FIRST:     cmd.restart = 1'b1;
			S_FIRST_PUT: begin
				cmd.put_clear  = sts.pk_ready;
				cmd.take_pixel = sts.pk_ready;
			end
			S_READ:      cmd.rd_en = 1'b1;
			S_CMP: begin
				cmd.take_hit   = sts.hit;
				cmd.probe_next = !sts.hit && !sts.slot_empty;
			end
			S_MISS_PUT:  cmd.put_prefix = sts.pk_ready;
			S_ADD: begin
				cmd.add_entry  = 1'b1;
				cmd.take_pixel = 1'b1;
			end
			S_FULL_PUT:  cmd.put_clear = sts.pk_ready;
			S_RESTART: begin
				cmd.restart    = 1'b1;
				cmd.take_pixel = 1'b1;
			end
			S_CHECK:      ;
			S_FIN_PREFIX: cmd.put_prefix = sts.pk_ready;
			S_FIN_STOP: begin
				cmd.put_stop  = sts.pk_ready;
				cmd.start_fin = sts.pk_ready;
			end
			S_FLUSH:      cmd.end_image = !sts.fin_busy;
			default:      ;
		endcase
	end

endmodule

/* src/gle_dpath.sv */
// ----------------------------------------------------------------------------
// gle_dpath
// Dictionary memory with epoch tags, code state, bit packer and output register.
// ----------------------------------------------------------------------------
module gle_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gle_pkg::DEPTH_W-1:0]   cfg_wdata,
	input  logic [gle_pkg::PIX_W-1:0]     pix_in,
	input  logic                          last_in,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [7:0]                    m_tdata,
	output logic [1:0]                    m_tuser,
	input  gle_pkg::cmd_t                 cmd,
	output gle_pkg::sts_t                 sts
);
	import gle_pkg::*;

	logic [DEPTH_W-1:0] depth_cfg_q;
	logic [DEPTH_W-1:0] depth;
	logic [CODE_W-1:0]  clear_code;
	logic [PIX_W-1:0]   pix_masked;

	logic [PIX_W-1:0]   pix_q;
	logic               last_q;
	logic               started_q;
	logic [CODE_W-1:0]  prefix_q;
	logic [NEXT_W-1:0]  next_q;
	logic [DEPTH_W-1:0] width_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               sweep_pend_q;
	logic [SLOT_W-1:0]  sweep_idx_q;
	logic [SLOT_W-1:0]  idx_q;

	logic               ram_we;
	logic [SLOT_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	logic [EPOCH_W-1:0] rd_epoch;
	logic [CODE_W-1:0]  rd_prefix;
	logic [PIX_W-1:0]   rd_pix;
	logic [CODE_W-1:0]  rd_code;

	logic [ACC_W-1:0]   acc_q;
	logic [PEND_W-1:0]  pend_q;
	logic               fin_q;
	logic [SBC_W-1:0]   sbc_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic [1:0]         out_flags_q;

	logic               put;
	logic [CODE_W-1:0]  put_code;
	logic [CODE_W-1:0]  put_mask;
	logic               emit;
	logic [PEND_W-1:0]  pend_after;
	logic               final_byte;
	logic [SBC_W-1:0]   sbc_inc;

	// effective depth and clear code
	always_comb begin
		if (depth_cfg_q < DEPTH_MIN) begin
			depth = DEPTH_MIN;
		end else if (depth_cfg_q > DEPTH_MAX) begin
			depth = DEPTH_MAX;
		end else begin
			depth = depth_cfg_q;
		end
		clear_code = CODE_W'(1) << depth;
		pix_masked = pix_in & PIX_W'(clear_code - CODE_W'(1));
	end

	// configuration register, locked while an image is open
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_cfg_q <= DEPTH_MAX;
		end else if (cfg_we && !started_q) begin
			depth_cfg_q <= cfg_wdata;
		end
	end

	// dictionary memory
	gle_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SLOTS)
	) u_dict (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_en),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign ram_we    = cmd.sweep_step || cmd.add_entry;
	assign ram_waddr = cmd.sweep_step ? sweep_idx_q : idx_q;
	assign ram_wdata = cmd.sweep_step ? '0
		: {epoch_q, prefix_q, pix_q, next_q[CODE_W-1:0]};
	assign {rd_epoch, rd_prefix, rd_pix, rd_code} = ram_rdata;

	// code state, probing and epoch bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			prefix_q     <= '0;
			next_q       <= NEXT_W'(CODE_W'(1) << DEPTH_MAX) + NEXT_W'(2);
			width_q      <= DEPTH_MAX + DEPTH_W'(1);
			epoch_q      <= EPOCH_FIRST;
			sweep_pend_q <= 1'b1;
			sweep_idx_q  <= '0;
			idx_q        <= '0;
			last_q       <= 1'b0;
			pix_q        <= '0;
		end else begin
			if (cmd.accept) begin
				pix_q  <= pix_masked;
				last_q <= last_in;
				idx_q  <= SLOT_W'({prefix_q, pix_masked} % TABLE_SLOTS);
			end
			if (cmd.probe_next) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
			if (cmd.sweep_step) begin
				sweep_idx_q <= sweep_idx_q + SLOT_W'(1);
				if (sts.sweep_last) begin
					sweep_pend_q <= 1'b0;
				end
			end
			if (cmd.restart) begin
				started_q <= 1'b1;
				next_q    <= NEXT_W'(clear_code) + NEXT_W'(2);
				width_q   <= depth + DEPTH_W'(1);
				if (epoch_q == EPOCH_LAST) begin
					epoch_q      <= EPOCH_FIRST;
					sweep_pend_q <= 1'b1;
				end else begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
			end
			if (cmd.add_entry) begin
				next_q <= next_q + NEXT_W'(1);
				if (next_q == (NEXT_W'(1) << width_q)) begin
					width_q <= width_q + DEPTH_W'(1);
				end
			end
			if (cmd.take_hit) begin
				prefix_q <= rd_code;
			end
			if (cmd.take_pixel) begin
				prefix_q <= CODE_W'(pix_q);
			end
			if (cmd.end_image) begin
				started_q <= 1'b0;
			end
		end
	end

	// code to be packed
	always_comb begin
		put      = cmd.put_prefix || cmd.put_clear || cmd.put_stop;
		put_code = prefix_q;
		if (cmd.put_clear) begin
			put_code = clear_code;
		end else if (cmd.put_stop) begin
			put_code = clear_code + CODE_W'(1);
		end
		put_mask = ~({CODE_W{1'b1}} << width_q);
	end

	// byte emission
	assign emit       = (!out_valid_q || m_tready)
		&& (pend_q >= PEND_W'(8) || (fin_q && pend_q != '0));
	assign pend_after = (pend_q >= PEND_W'(8)) ? pend_q - PEND_W'(8) : '0;
	assign final_byte = fin_q && pend_after == '0;
	assign sbc_inc    = sbc_q + SBC_W'(1);

	// bit packer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			pend_q      <= '0;
			fin_q       <= 1'b0;
			sbc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (put) begin
				acc_q  <= acc_q | (ACC_W'(put_code & put_mask) << pend_q);
				pend_q <= pend_q + PEND_W'(width_q);
			end else if (emit) begin
				acc_q  <= final_byte ? '0 : acc_q >> 8;
				pend_q <= pend_after;
			end
			if (cmd.start_fin) begin
				fin_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= acc_q[7:0];
				if (final_byte) begin
					fin_q       <= 1'b0;
					sbc_q       <= '0;
					out_flags_q <= 2'b11;
				end else if (32'(sbc_inc) >= SUB_BLOCK_BYTES) begin
					sbc_q       <= '0;
					out_flags_q <= 2'b01;
				end else begin
					sbc_q       <= sbc_inc;
					out_flags_q <= 2'b00;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_flags_q;

	// status to the controller
	always_comb begin
		sts.sweep_pending = sweep_pend_q;
		sts.sweep_last    = sweep_idx_q == {SLOT_W{1'b1}};
		sts.started       = started_q;
		sts.last_pix      = last_q;
		sts.slot_empty    = rd_epoch != epoch_q;
		sts.hit           = !sts.slot_empty && rd_prefix == prefix_q && rd_pix == pix_q;
		sts.dict_full     = 32'(next_q) >= MAX_CODES;
		sts.pk_ready      = pend_q < PEND_W'(8);
		sts.fin_busy      = fin_q;
	end

endmodule

/* src/gif_lzw_pixel_encoder_top.sv */
// ----------------------------------------------------------------------------
// gif_lzw_pixel_encoder_top
// GIF-style variable-width LZW encoder of color-index pixels into packed bytes.
// ----------------------------------------------------------------------------
// Input: a new pixel is accepted only once the previous one has been handled;
// each lookup probe is a read of the dictionary RAM, and a miss also packs a code.
// Output: packed bytes leave through a registered output that holds while stalled.
// Reset: asynchronous; afterwards a sweep tags every dictionary
// slot stale, and the same sweep reruns after every 15 dictionary restarts.
module gif_lzw_pixel_encoder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gle_pkg::DEPTH_W-1:0] cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // pixel_index
	input  logic                        s_tlast,  // last_pixel
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,  // data_byte
	output logic [1:0]                  m_tuser   // ends_sub_block, ends_image
);
	import gle_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	gle_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// datapath
	gle_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.pix_in   (s_tdata),
		.last_in  (s_tlast),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

/* src/gle_checker.sv */
// ----------------------------------------------------------------------------
// gle_checker
// Port-level checks of the LZW encoder, bound to the top level.
// ----------------------------------------------------------------------------
module gle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser
);

	// a stalled output transfer holds its byte
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	// the image end byte also closes its sub-block
	a_end_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("image end without sub-block end");

	// one pixel at a time: no input transfer right after another
	a_one_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transfer");

endmodule

bind gif_lzw_pixel_encoder_top gle_checker u_gle_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
